// File: hdl/iqc_pkg.sv
// Shared types, codes and helpers for the I/Q imbalance corrector.
// Used by iqc_front, iqc_queue, iqc_back and iq_imbalance_corrector.
package iqc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 12;
   localparam int GAIN_W   = 17;          // unsigned Q2.14 with a zero sign bit
   localparam int NUM_STATS = 8;
   localparam int STAT_ID_W = 3;

   // opcode of a request
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // kind of a response
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STAT   = 1'b1;

   // stat_id bit fields
   localparam int STAT_MIN_BIT  = 0;      // 0 = max, 1 = min
   localparam int STAT_IM_BIT   = 1;      // 0 = re, 1 = im
   localparam int STAT_CORR_BIT = 2;      // 0 = raw, 1 = corrected

   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16384);
   localparam logic [STAT_ID_W-1:0] LAST_STAT_ID = STAT_ID_W'(NUM_STATS - 1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] re;
      logic [SAMPLE_W-1:0] im;
      logic [SAMPLE_W-1:0] phase;
      logic [GAIN_W-1:0]   gain;
      logic [INDEX_W-1:0]  index;
      logic                last;
   } iqc_sample_type;

   typedef struct packed {
      logic                 kind;
      logic [SAMPLE_W-1:0]  out_re;
      logic [SAMPLE_W-1:0]  out_im;
      logic [STAT_ID_W-1:0] stat_id;
      logic [SAMPLE_W-1:0]  stat_value;
      logic [INDEX_W-1:0]   stat_position;
      logic                 last;
   } iqc_result_type;

   // saturate a 19-bit signed value to 16 bits
   function automatic logic [SAMPLE_W-1:0] sat16(input logic [18:0] v);
      logic [SAMPLE_W-1:0] r;
      if ((v[18:15] == 4'b0000) || (v[18:15] == 4'b1111)) begin
         r = v[15:0];
      end else if (v[18]) begin
         r = 16'h8000;
      end else begin
         r = 16'h7FFF;
      end
      return r;
   endfunction

endpackage

// File: hdl/iqc_front.sv
// Front end: accepts requests, performs table writes, looks up phase/gain
// for samples. Depends on iqc_pkg.
module iqc_front
   import iqc_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_opcode,
   input  logic [INDEX_W-1:0]  in_index,
   input  logic [SAMPLE_W-1:0] in_re,
   input  logic [SAMPLE_W-1:0] in_im,
   input  logic [SAMPLE_W-1:0] in_phase,
   input  logic [SAMPLE_W-1:0] in_gain,
   input  logic                in_last,
   output logic                out_valid,
   input  logic                out_ready,
   output iqc_sample_type      out_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EXT_W  = 17;
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(TABLE_DEPTH);

   logic [SAMPLE_W-1:0] phase_mem [TABLE_DEPTH];
   logic [SAMPLE_W-1:0] gain_mem  [TABLE_DEPTH];

   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] phase_rd_ff, gain_rd_ff;
   logic [SAMPLE_W-1:0] re_ff, im_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                last_ff, in_range_ff;

   logic [EXT_W-1:0]    index_ext;
   logic [ADDR_W-1:0]   addr;
   logic                in_range, accept, is_write;

   assign index_ext = EXT_W'(in_index);
   assign addr      = index_ext[ADDR_W-1:0];
   assign in_range  = index_ext < DEPTH_EXT;
   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign is_write  = (in_opcode == OP_WRITE);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = !is_write;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_write && in_range) begin
         phase_mem[addr] <= in_phase;
         gain_mem[addr]  <= in_gain;
      end
      if (accept && !is_write) begin
         phase_rd_ff <= phase_mem[addr];
         gain_rd_ff  <= gain_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_write) begin
         re_ff       <= in_re;
         im_ff       <= in_im;
         index_ff    <= in_index;
         last_ff     <= in_last;
         in_range_ff <= in_range;
      end
   end

   // out-of-range positions pass through: phase 0, gain 1.0
   always_comb begin
      out_data.re    = re_ff;
      out_data.im    = im_ff;
      out_data.index = index_ff;
      out_data.last  = last_ff;
      out_data.phase = in_range_ff ? phase_rd_ff : '0;
      out_data.gain  = in_range_ff ? GAIN_W'(gain_rd_ff) : GAIN_UNITY;
   end

   assign out_valid = valid_ff;

endmodule

// File: hdl/iqc_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on iqc_pkg.
module iqc_queue
   import iqc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  iqc_sample_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output iqc_sample_type pop_data
);

   iqc_sample_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/iqc_back.sv
// Back end: multiply, round toward zero, saturate, track extremes and
// emit sample results and statistic records. Depends on iqc_pkg.
module iqc_back
   import iqc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  iqc_sample_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output iqc_result_type out_data
);

   // multiply stage
   logic                b1_valid_ff, b1_valid_in;
   logic signed [31:0]  b1_prod_ph_ff;
   logic signed [32:0]  b1_prod_gn_ff;
   logic [SAMPLE_W-1:0] b1_re_ff, b1_im_ff;
   logic [INDEX_W-1:0]  b1_index_ff;
   logic                b1_last_ff;

   // round/saturate stage
   logic                b2_valid_ff, b2_valid_in;
   logic [SAMPLE_W-1:0] b2_re_ff, b2_im_ff, b2_cre_ff, b2_cim_ff;
   logic [INDEX_W-1:0]  b2_index_ff;
   logic                b2_last_ff;

   // output and statistics
   logic                rsp_valid_ff, rsp_valid_in;
   iqc_result_type      rsp_ff, rsp_in;
   logic                emit_ff, emit_in;
   logic [STAT_ID_W-1:0] stat_cnt_ff, stat_cnt_in;
   logic [SAMPLE_W-1:0] ext_val_ff [NUM_STATS];
   logic [INDEX_W-1:0]  ext_pos_ff [NUM_STATS];

   logic out_load, b2_take, b2_ready, b1_ready, b1_take;
   logic signed [32:0] sum_im, sum_im_r, sum_re_r;
   logic [18:0]        q_im, q_re;
   logic [SAMPLE_W-1:0] cre, cim;

   assign out_load = !rsp_valid_ff || out_ready;
   assign b2_take  = out_load && !emit_ff && b2_valid_ff;
   assign b2_ready = !b2_valid_ff || b2_take;
   assign b1_take  = b1_valid_ff && b2_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign in_ready = b1_ready;

   // ---- multiply
   always_comb begin
      b1_valid_in = b1_valid_ff;
      if (in_valid && b1_ready) begin
         b1_valid_in = 1'b1;
      end else if (b1_take) begin
         b1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && b1_ready) begin
         b1_prod_ph_ff <= $signed(in_data.phase) * $signed(in_data.re);
         b1_prod_gn_ff <= $signed(in_data.gain) * $signed(in_data.re);
         b1_re_ff      <= in_data.re;
         b1_im_ff      <= in_data.im;
         b1_index_ff   <= in_data.index;
         b1_last_ff    <= in_data.last;
      end
   end

   // ---- round toward zero and saturate
   always_comb begin
      sum_im   = $signed({{2{b1_im_ff[SAMPLE_W-1]}}, b1_im_ff, 15'(0)})
                 + 33'(b1_prod_ph_ff);
      sum_im_r = sum_im + (sum_im[32] ? 33'sd32767 : 33'sd0);
      sum_re_r = b1_prod_gn_ff + (b1_prod_gn_ff[32] ? 33'sd16383 : 33'sd0);
      q_im     = {sum_im_r[32], sum_im_r[32:15]};
      q_re     = sum_re_r[32:14];
      cim      = sat16(q_im);
      cre      = sat16(q_re);
   end

   always_comb begin
      b2_valid_in = b2_valid_ff;
      if (b1_take) begin
         b2_valid_in = 1'b1;
      end else if (b2_take) begin
         b2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_take) begin
         b2_re_ff    <= b1_re_ff;
         b2_im_ff    <= b1_im_ff;
         b2_cre_ff   <= cre;
         b2_cim_ff   <= cim;
         b2_index_ff <= b1_index_ff;
         b2_last_ff  <= b1_last_ff;
      end
   end

   // ---- extremes: one compare per statistic per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STATS; i++) begin
            ext_val_ff[i] <= '0;
            ext_pos_ff[i] <= '0;
         end
      end else if (b2_take) begin
         for (int i = 0; i < NUM_STATS; i++) begin
            logic [STAT_ID_W-1:0] id;
            logic [SAMPLE_W-1:0]  base, v;
            logic                 hit;
            id   = STAT_ID_W'(i);
            base = (b2_index_ff == '0) ? '0 : ext_val_ff[i];
            if (id[STAT_CORR_BIT]) begin
               v = id[STAT_IM_BIT] ? b2_cim_ff : b2_cre_ff;
            end else begin
               v = id[STAT_IM_BIT] ? b2_im_ff : b2_re_ff;
            end
            hit = id[STAT_MIN_BIT] ? ($signed(v) <= $signed(base))
                                   : ($signed(v) >= $signed(base));
            ext_val_ff[i] <= hit ? v : base;
            if (hit) begin
               ext_pos_ff[i] <= b2_index_ff;
            end
         end
      end
   end

   // ---- output register and record sequencing
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      emit_in      = emit_ff;
      stat_cnt_in  = stat_cnt_ff;
      if (out_load) begin
         rsp_valid_in = 1'b0;
         if (emit_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = KIND_STAT;
            rsp_in.out_re        = '0;
            rsp_in.out_im        = '0;
            rsp_in.stat_id       = stat_cnt_ff;
            rsp_in.stat_value    = ext_val_ff[stat_cnt_ff];
            rsp_in.stat_position = ext_pos_ff[stat_cnt_ff];
            rsp_in.last          = (stat_cnt_ff == LAST_STAT_ID);
            stat_cnt_in          = stat_cnt_ff + 1'b1;
            emit_in              = (stat_cnt_ff != LAST_STAT_ID);
         end else if (b2_valid_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = KIND_SAMPLE;
            rsp_in.out_re        = b2_cre_ff;
            rsp_in.out_im        = b2_cim_ff;
            rsp_in.stat_id       = '0;
            rsp_in.stat_value    = '0;
            rsp_in.stat_position = '0;
            rsp_in.last          = !b2_last_ff;
            emit_in              = b2_last_ff;
            stat_cnt_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emit_ff      <= 1'b0;
         stat_cnt_ff  <= '0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_ff      <= emit_in;
         stat_cnt_ff  <= stat_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// File: hdl/iq_imbalance_corrector.sv
// I/Q imbalance corrector, top level. Throughput: one request per
// cycle while the response side accepts; a sample with tlast adds 8
// statistic records, which hold the back end. Table writes produce
// no response. Reset clears the pipeline and the extremes; the
// phase/gain tables are not cleared.
module iq_imbalance_corrector
   import iqc_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // index[11:0], sample_re[27:12], sample_im[43:28], phase_word[59:44],
   // gain_word[75:60], zero pad[79:76]
   input  logic [79:0] req_tdata,
   input  logic        req_tuser,   // opcode
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_re[15:0], out_im[31:16], stat_id[34:32], stat_value[50:35],
   // stat_position[62:51], zero pad[63]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last_result
);

   logic           f_valid, f_ready, b_valid, b_ready;
   iqc_sample_type f_data, b_data;
   iqc_result_type rsp;

   iqc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_opcode (req_tuser),
      .in_index  (req_tdata[11:0]),
      .in_re     (req_tdata[27:12]),
      .in_im     (req_tdata[43:28]),
      .in_phase  (req_tdata[59:44]),
      .in_gain   (req_tdata[75:60]),
      .in_last   (req_tlast),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   iqc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   iqc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_data   (b_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.stat_position, rsp.stat_value, rsp.stat_id,
                       rsp.out_im, rsp.out_re};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

// File: test/iq_imbalance_corrector_tb.sv
// Self-checking testbench for iq_imbalance_corrector: directed and random requests
// against a behavioral scoreboard of the gain/phase correction and buffer extremes.
// Depends on iqc_pkg and the iq_imbalance_corrector RTL.
module iq_imbalance_corrector_tb;
   import iqc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit          opcode;
      bit [11:0]   index;
      shortint     re;
      shortint     im;
      shortint     phase;
      bit [15:0]   gain;
      bit          last;
   } iq_request_type;

   class iq_scoreboard;
      shortint         phase_tbl [4096];
      bit [15:0]       gain_tbl [4096];
      shortint         ext_val [NUM_STATS];
      bit [11:0]       ext_pos [NUM_STATS];
      iqc_result_type  expected_q [$];
      int              failures;

      function int pending();
         return expected_q.size();
      endfunction

      function shortint clamp16(longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return -16'sh8000;
         return shortint'(v);
      endfunction

      // ties replace the stored extreme, so the later position wins
      function void track_extreme(bit [2:0] id, shortint v, bit [11:0] pos);
         bit take;
         take = id[STAT_MIN_BIT] ? (v <= ext_val[id]) : (v >= ext_val[id]);
         if (take) begin
            ext_val[id] = v;
            ext_pos[id] = pos;
         end
      endfunction

      function void note_request(iq_request_type r);
         longint re, im, ph, gn;
         shortint cre, cim, v;
         bit [2:0] id;
         iqc_result_type res;
         if (r.opcode == OP_WRITE) begin
            phase_tbl[r.index] = r.phase;
            gain_tbl[r.index] = r.gain;
            return;
         end
         if (r.index == 0) begin
            foreach (ext_val[i]) ext_val[i] = 0;
         end
         re = r.re;
         im = r.im;
         ph = phase_tbl[r.index];
         gn = gain_tbl[r.index];
         // longint division truncates toward zero
         cim = clamp16((im * 32768 + ph * re) / 32768);
         cre = clamp16((re * gn) / 16384);
         for (int s = 0; s < NUM_STATS; s++) begin
            id = s[2:0];
            if (id[STAT_CORR_BIT]) v = id[STAT_IM_BIT] ? cim : cre;
            else v = id[STAT_IM_BIT] ? r.im : r.re;
            track_extreme(id, v, r.index);
         end
         res = '0;
         res.kind = KIND_SAMPLE;
         res.out_re = cre;
         res.out_im = cim;
         res.last = !r.last;
         expected_q.push_back(res);
         if (r.last) begin
            for (int s = 0; s < NUM_STATS; s++) begin
               res = '0;
               res.kind = KIND_STAT;
               res.stat_id = s[2:0];
               res.stat_value = ext_val[s];
               res.stat_position = ext_pos[s];
               res.last = (s[2:0] == LAST_STAT_ID);
               expected_q.push_back(res);
            end
         end
      endfunction

      function void check_result(iqc_result_type got);
         iqc_result_type exp;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected response kind=%0d", got.kind);
            return;
         end
         exp = expected_q.pop_front();
         if (got !== exp) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected kind=%0d re=%h im=%h id=%0d val=%h pos=%h last=%0d",
                        exp.kind, exp.out_re, exp.out_im, exp.stat_id, exp.stat_value,
                        exp.stat_position, exp.last);
               $display("          actual   kind=%0d re=%h im=%h id=%0d val=%h pos=%h last=%0d",
                        got.kind, got.out_re, got.out_im, got.stat_id, got.stat_value,
                        got.stat_position, got.last);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;     // index, sample_re, sample_im, phase_word, gain_word, pad
   logic        req_tuser = 1'b0;   // opcode
   logic        req_tlast = 1'b0;   // last_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // out_re, out_im, stat_id, stat_value, stat_position, pad
   logic        rsp_tuser;          // kind
   logic        rsp_tlast;          // last_result

   iq_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  written [4096];
   int  written_list [$];

   iq_imbalance_corrector dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // response side: sample the handshake, then pick the next tready
   always @(posedge clock) begin
      iqc_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.out_re = rsp_tdata[15:0];
         got.out_im = rsp_tdata[31:16];
         got.stat_id = rsp_tdata[34:32];
         got.stat_value = rsp_tdata[50:35];
         got.stat_position = rsp_tdata[62:51];
         got.last = rsp_tlast;
         sb.check_result(got);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic push_request(input iq_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.opcode;
      req_tlast <= r.last;
      req_tdata <= {4'b0, r.gain, r.phase, r.im, r.re, r.index};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      if (r.opcode == OP_WRITE && !written[r.index]) begin
         written[r.index] = 1'b1;
         written_list.push_back(r.index);
      end
   endtask

   task automatic put_write(input bit [11:0] idx, input shortint ph, input bit [15:0] gn);
      iq_request_type r;
      r = '{OP_WRITE, idx, 16'sd0, 16'sd0, ph, gn, 1'b0};
      push_request(r);
   endtask

   task automatic put_sample(input bit [11:0] idx, input shortint re, input shortint im,
                             input bit last);
      iq_request_type r;
      r = '{OP_SAMPLE, idx, re, im, 16'sd0, 16'd0, last};
      push_request(r);
   endtask

   // hold off new requests until every expected response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic shortint rand_sample();
      case ($urandom_range(9))
         0: return -16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return shortint'($urandom_range(64)) - 16'sd32;
         default: return shortint'($urandom);
      endcase
   endfunction

   function automatic bit [15:0] rand_gain();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic put_random_write(input bit [11:0] idx);
      put_write(idx, rand_sample(), rand_gain());
   endtask

   // a buffer from position 0; tables at every position are loaded first
   task automatic put_buffer(input int len, input bit with_last);
      for (int k = 0; k < len; k++) begin
         if (!written[k]) put_random_write(k[11:0]);
      end
      for (int k = 0; k < len; k++) begin
         put_sample(k[11:0], rand_sample(), rand_sample(), with_last && (k == len - 1));
      end
   endtask

   initial begin
      int items;
      int len;
      int pick;
      int idle_pct [4];
      int stall_pct [4];

      idle_pct = '{0, 48, 0, 38};
      stall_pct = '{0, 0, 48, 38};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme coefficients and samples, saturation, ties
      put_write(12'd0, 16'sh7FFF, 16'd16384);
      put_write(12'd1, -16'sh8000, 16'hFFFF);
      put_write(12'd2, 16'sd0, 16'd0);
      put_write(12'd3, 16'sd12345, 16'd20000);
      put_write(12'd4, -16'sd1, 16'd1);
      put_write(12'd4095, 16'sh7FFF, 16'hFFFF);
      put_write(12'd2730, -16'sh8000, 16'd0);
      put_sample(12'd0, 16'sh7FFF, -16'sh8000, 1'b0);
      put_sample(12'd1, -16'sh8000, 16'sh7FFF, 1'b0);
      put_sample(12'd2, -16'sh8000, -16'sh8000, 1'b0);
      put_sample(12'd3, -16'sh8000, 16'sh7FFF, 1'b0);
      put_sample(12'd4, 16'sh7FFF, 16'sh7FFF, 1'b1);
      // mid-buffer positions without a fresh start
      put_sample(12'd4095, -16'sh8000, 16'sh7FFF, 1'b0);
      put_sample(12'd2730, 16'sh7FFF, -16'sh8000, 1'b1);
      // max stays below zero and min above zero: old positions remain
      put_sample(12'd0, -16'sd5, 16'sd3, 1'b0);
      put_sample(12'd1, -16'sd5, 16'sd3, 1'b0);
      put_sample(12'd2, -16'sd7, 16'sd1, 1'b1);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         items = 0;
         while (items < 100) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
            if (pick < 65) begin
               put_buffer(len, 1'b1);
               items += len;
            end else if (pick < 78) begin
               put_random_write($urandom_range(1) ? 12'($urandom_range(4095))
                                                  : 12'($urandom_range(15)));
               items += 1;
            end else if (pick < 92) begin
               put_sample(12'(written_list[$urandom_range(written_list.size() - 1)]),
                          rand_sample(), rand_sample(), 1'($urandom_range(1)));
               items += 1;
            end else begin
               // broken buffer: no closing sample
               put_buffer(len, 1'b0);
               items += len;
            end
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/iqc_pkg.sv
hdl/iqc_front.sv
hdl/iqc_queue.sv
hdl/iqc_back.sv
hdl/iq_imbalance_corrector.sv
test/iq_imbalance_corrector_tb.sv
